// ===== src/avr_pkg.sv =====
// shared types, constants and functions of the axis vector rotator
`timescale 1ns / 1ps

package avr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;
  localparam int GUARD_BITS       = 16;
  localparam int ANGLE_BITS       = 16;
  localparam int ZW               = 32;
  localparam int GAIN_BITS        = 31;
  localparam int ATAN_LEN         = 24;

  localparam longint INV_K_INF       = 64'd652032874;
  localparam longint INV_K_TWO_THIRD = (INV_K_INF * 2) / 3;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic  valid;
    logic  bypass;
    axis_t axis;
  } ctrl_t;

  // inverse cordic gain in q1.30 for a given number of steps
  function automatic logic [GAIN_BITS-1:0] inv_gain(input int steps);
    longint g;
    g = INV_K_INF + (INV_K_TWO_THIRD >>> (2 * steps));
    return g[GAIN_BITS-1:0];
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ZW-1:0] atan_turn(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/avr_req_if.sv =====
// request channel: axis, angle and the three input coordinates
`timescale 1ns / 1ps

interface avr_req_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [15:0]                  angle;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, req_type, angle, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, angle, coord_x, coord_y, coord_z, output ready);
endinterface

// ===== src/avr_res_if.sv =====
// result channel: the rotated vector
`timescale 1ns / 1ps

interface avr_res_if #(
  parameter int COORD_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] rot_x;
  logic signed [COORD_BITS:0] rot_y;
  logic signed [COORD_BITS:0] rot_z;

  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== src/avr_prescale.sv =====
// front stage: axis select, quadrant fold and gain pre-scaling
`timescale 1ns / 1ps

module avr_prescale #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 16,
  parameter int WW           = COORD_BITS + 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    in_type,
  input  logic [15:0]                   in_angle,
  input  logic signed [COORD_BITS-1:0]  in_x,
  input  logic signed [COORD_BITS-1:0]  in_y,
  input  logic signed [COORD_BITS-1:0]  in_z,
  output avr_pkg::ctrl_t                ctrl,
  output logic signed [WW-1:0]          a,
  output logic signed [WW-1:0]          b,
  output logic signed [avr_pkg::ZW-1:0] z,
  output logic signed [COORD_BITS-1:0]  p
);
  import avr_pkg::*;

  localparam int PW = COORD_BITS + GAIN_BITS + 1;
  localparam logic [GAIN_BITS-1:0] GAIN = inv_gain(CORDIC_STEPS);

  axis_t                        axis;
  logic                         bypass;
  logic                         fold;
  logic [ANGLE_BITS-1:0]        res_angle;
  logic signed [COORD_BITS-1:0] a_sel;
  logic signed [COORD_BITS-1:0] b_sel;
  logic signed [COORD_BITS-1:0] p_sel;
  logic signed [COORD_BITS:0]   a_fold;
  logic signed [COORD_BITS:0]   b_fold;
  logic signed [GAIN_BITS:0]    gain_s;
  logic signed [PW-1:0]         a_prod;
  logic signed [PW-1:0]         b_prod;

  assign axis      = axis_t'(in_type);
  assign bypass    = (axis == AXIS_NONE);
  assign fold      = in_angle[15] ^ in_angle[14];
  assign res_angle = {in_angle[15] ^ fold, in_angle[14:0]};
  assign gain_s    = $signed({1'b0, GAIN});

  always_comb begin
    unique case (axis)
      AXIS_X: begin
        a_sel = in_y;
        b_sel = in_z;
        p_sel = in_x;
      end
      AXIS_Y: begin
        a_sel = in_x;
        b_sel = in_z;
        p_sel = in_y;
      end
      default: begin
        a_sel = in_x;
        b_sel = in_y;
        p_sel = in_z;
      end
    endcase
  end

  always_comb begin
    a_fold = fold ? -{a_sel[COORD_BITS-1], a_sel} : {a_sel[COORD_BITS-1], a_sel};
    b_fold = fold ? -{b_sel[COORD_BITS-1], b_sel} : {b_sel[COORD_BITS-1], b_sel};
    a_prod = PW'(a_fold) * PW'(gain_s);
    b_prod = PW'(b_fold) * PW'(gain_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= in_valid;
    end
    if (en) begin
      ctrl.bypass <= bypass;
      ctrl.axis   <= axis;
      p           <= p_sel;
      z           <= $signed({res_angle, {(ZW - ANGLE_BITS){1'b0}}});
      if (bypass) begin
        a <= WW'(a_sel);
        b <= WW'(b_sel);
      end else begin
        a <= a_prod[PW-1:30-GUARD_BITS];
        b <= b_prod[PW-1:30-GUARD_BITS];
      end
    end
  end

endmodule

// ===== src/avr_cell.sv =====
// one cordic micro-rotation cell of the chain
`timescale 1ns / 1ps

module avr_cell #(
  parameter int STEP       = 0,
  parameter int COORD_BITS = 16,
  parameter int WW         = COORD_BITS + 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  avr_pkg::ctrl_t                ctrl_in,
  input  logic signed [WW-1:0]          a_in,
  input  logic signed [WW-1:0]          b_in,
  input  logic signed [avr_pkg::ZW-1:0] z_in,
  input  logic signed [COORD_BITS-1:0]  p_in,
  output avr_pkg::ctrl_t                ctrl_out,
  output logic signed [WW-1:0]          a_out,
  output logic signed [WW-1:0]          b_out,
  output logic signed [avr_pkg::ZW-1:0] z_out,
  output logic signed [COORD_BITS-1:0]  p_out
);
  import avr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_turn(STEP);

  logic signed [WW-1:0] da;
  logic signed [WW-1:0] db;

  assign da = b_in >>> STEP;
  assign db = a_in >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.bypass <= ctrl_in.bypass;
      ctrl_out.axis   <= ctrl_in.axis;
      p_out           <= p_in;
      if (ctrl_in.bypass) begin
        a_out <= a_in;
        b_out <= b_in;
        z_out <= z_in;
      end else if (!z_in[ZW-1]) begin
        a_out <= a_in - da;
        b_out <= b_in + db;
        z_out <= z_in - ATAN;
      end else begin
        a_out <= a_in + da;
        b_out <= b_in - db;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

// ===== src/avr_post.sv =====
// back stage: rounding, vector reassembly, output register and skid buffer
`timescale 1ns / 1ps

module avr_post #(
  parameter int COORD_BITS = 16,
  parameter int WW         = COORD_BITS + 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  avr_pkg::ctrl_t               ctrl,
  input  logic signed [WW-1:0]         a,
  input  logic signed [WW-1:0]         b,
  input  logic signed [COORD_BITS-1:0] p,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_x,
  output logic signed [COORD_BITS:0]   out_y,
  output logic signed [COORD_BITS:0]   out_z
);
  import avr_pkg::*;

  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (GUARD_BITS - 1);

  logic signed [WW-1:0]       a_sum;
  logic signed [WW-1:0]       b_sum;
  logic signed [COORD_BITS:0] ra;
  logic signed [COORD_BITS:0] rb;
  logic signed [COORD_BITS:0] pe;
  logic signed [COORD_BITS:0] vx;
  logic signed [COORD_BITS:0] vy;
  logic signed [COORD_BITS:0] vz;
  logic                       skid_valid;
  logic signed [COORD_BITS:0] skid_x;
  logic signed [COORD_BITS:0] skid_y;
  logic signed [COORD_BITS:0] skid_z;
  logic                       beat_in;

  assign a_sum = a + HALF;
  assign b_sum = b + HALF;
  assign ra    = ctrl.bypass ? a[COORD_BITS:0] : a_sum[COORD_BITS+GUARD_BITS:GUARD_BITS];
  assign rb    = ctrl.bypass ? b[COORD_BITS:0] : b_sum[COORD_BITS+GUARD_BITS:GUARD_BITS];
  assign pe    = (COORD_BITS + 1)'(p);

  always_comb begin
    unique case (ctrl.axis)
      AXIS_X: begin
        vx = pe;
        vy = ra;
        vz = rb;
      end
      AXIS_Y: begin
        vx = ra;
        vy = pe;
        vz = rb;
      end
      default: begin
        vx = ra;
        vy = rb;
        vz = pe;
      end
    endcase
  end

  assign take    = !skid_valid;
  assign beat_in = ctrl.valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (beat_in) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (beat_in) begin
        skid_x <= vx;
        skid_y <= vy;
        skid_z <= vz;
      end
    end else if (skid_valid) begin
      out_x <= skid_x;
      out_y <= skid_y;
      out_z <= skid_z;
    end else begin
      out_x <= vx;
      out_y <= vy;
      out_z <= vz;
    end
  end

endmodule

// ===== src/axis_vector_rotator_core.sv =====
// top level of the axis vector rotator: prescale stage, cordic cell chain, output stage
`timescale 1ns / 1ps

// usage
// - req carries one vector per beat: rotation axis (x, y, z, or code three for
//   pass-through), a 16-bit binary angle and three signed q8.8 coordinates
// - res returns one rotated vector per request, in request order, as
//   17-bit (coord width plus one) signed q8.8 values rounded to nearest
// - the axis component passes through sign-extended; the other two are
//   rotated by a gain-compensated cordic
// - the pipeline is one prescale stage with the gain multiplier, one register
//   per cordic cell and one output register
// - throughput is one vector per cycle while res is not stalled; each cell of
//   the chain does one micro-rotation and hands its beat to the next cell every cycle
// - when res stalls, the output register holds and a one-entry skid buffer
//   takes the next finished beat; req.ready drops only while that buffer is
//   full, and the whole chain then holds in place
// - reset clears the valid bits of all stages, the output and the skid
//   buffer; the block is ready in the first cycle after reset

module axis_vector_rotator_core #(
  parameter int CORDIC_STEPS = avr_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = avr_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  avr_req_if.sink   req,
  avr_res_if.source res
);
  import avr_pkg::*;

  localparam int WW = COORD_BITS + 18;

  logic                         en;
  ctrl_t                        ctrl_s [CORDIC_STEPS+1];
  logic signed [WW-1:0]         a_s    [CORDIC_STEPS+1];
  logic signed [WW-1:0]         b_s    [CORDIC_STEPS+1];
  logic signed [ZW-1:0]         z_s    [CORDIC_STEPS+1];
  logic signed [COORD_BITS-1:0] p_s    [CORDIC_STEPS+1];

  assign req.ready = en;

  avr_prescale #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COORD_BITS   (COORD_BITS),
    .WW           (WW)
  ) u_prescale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (req.valid),
    .in_type  (req.req_type),
    .in_angle (req.angle),
    .in_x     (req.coord_x),
    .in_y     (req.coord_y),
    .in_z     (req.coord_z),
    .ctrl     (ctrl_s[0]),
    .a        (a_s[0]),
    .b        (b_s[0]),
    .z        (z_s[0]),
    .p        (p_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    avr_cell #(
      .STEP       (i),
      .COORD_BITS (COORD_BITS),
      .WW         (WW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl_s[i]),
      .a_in     (a_s[i]),
      .b_in     (b_s[i]),
      .z_in     (z_s[i]),
      .p_in     (p_s[i]),
      .ctrl_out (ctrl_s[i+1]),
      .a_out    (a_s[i+1]),
      .b_out    (b_s[i+1]),
      .z_out    (z_s[i+1]),
      .p_out    (p_s[i+1])
    );
  end

  avr_post #(
    .COORD_BITS (COORD_BITS),
    .WW         (WW)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_s[CORDIC_STEPS]),
    .a         (a_s[CORDIC_STEPS]),
    .b         (b_s[CORDIC_STEPS]),
    .p         (p_s[CORDIC_STEPS]),
    .take      (en),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_x     (res.rot_x),
    .out_y     (res.rot_y),
    .out_z     (res.rot_z)
  );

endmodule

// ===== verif/tb_axis_vector_rotator_core.sv =====
// testbench for axis_vector_rotator_core: random and corner vectors checked against a cordic predictor
`timescale 1ns / 1ps

module tb_axis_vector_rotator_core;
  import avr_pkg::*;

  localparam int     STEPS      = CORDIC_STEPS_DEF;
  localparam int     CW         = COORD_BITS_DEF;
  localparam int     N_RANDOM   = 950;
  localparam int     DRAIN      = STEPS + 24;
  localparam longint CYCLE_CAP  = 400000;

  typedef struct packed {
    logic signed [CW:0] x;
    logic signed [CW:0] y;
    logic signed [CW:0] z;
  } rot_vec_t;

  class rotation_scoreboard;
    localparam longint GAIN_Q30 = 64'd652032874 + (((64'd652032874 * 2) / 3) >>> (2 * STEPS));

    rot_vec_t expected_rot[$];
    int       n_fail;
    int       n_checked;
    int       n_sent;
    int       per_axis[4];

    function void rotate_pair(inout longint a, inout longint b, input logic [15:0] angle);
      longint      turn_acc;
      longint      da;
      longint      db;
      logic [15:0] r;
      int          i;
      longint      atan_tbl[16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
      };
      r = angle;
      // fold the left half plane onto the right one
      if (r >= 16'h4000 && r < 16'hC000) begin
        a = -a;
        b = -b;
        r = r - 16'h8000;
      end
      turn_acc = longint'($signed(r)) * 65536;
      a = (a * GAIN_Q30) >>> 14;
      b = (b * GAIN_Q30) >>> 14;
      for (i = 0; i < STEPS; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (turn_acc >= 0) begin
          a = a - da;
          b = b + db;
          turn_acc = turn_acc - atan_tbl[i];
        end else begin
          a = a + da;
          b = b - db;
          turn_acc = turn_acc + atan_tbl[i];
        end
      end
      a = (a + 64'sd32768) >>> 16;
      b = (b + 64'sd32768) >>> 16;
    endfunction

    function rot_vec_t rotate_vector(axis_t axis, logic [15:0] angle,
                                     logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                     logic signed [CW-1:0] cz);
      longint   x;
      longint   y;
      longint   z;
      rot_vec_t v;
      x = cx;
      y = cy;
      z = cz;
      case (axis)
        AXIS_X: rotate_pair(y, z, angle);
        AXIS_Y: rotate_pair(x, z, angle);
        AXIS_Z: rotate_pair(x, y, angle);
        default: ;
      endcase
      v.x = x[CW:0];
      v.y = y[CW:0];
      v.z = z[CW:0];
      return v;
    endfunction

    function void note_request(logic [1:0] axis, logic [15:0] angle, logic signed [CW-1:0] cx,
                               logic signed [CW-1:0] cy, logic signed [CW-1:0] cz);
      expected_rot.push_back(rotate_vector(axis_t'(axis), angle, cx, cy, cz));
      per_axis[axis]++;
      n_sent++;
    endfunction

    function void check_result(logic signed [CW:0] rx, logic signed [CW:0] ry,
                               logic signed [CW:0] rz);
      rot_vec_t want;
      if (expected_rot.size() == 0) begin
        if (n_fail < 10)
          $display("unexpected result (%0d, %0d, %0d)", rx, ry, rz);
        n_fail++;
        return;
      end
      want = expected_rot.pop_front();
      n_checked++;
      if (want.x !== rx || want.y !== ry || want.z !== rz) begin
        if (n_fail < 10)
          $display("mismatch on result %0d: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                   n_checked, want.x, want.y, want.z, rx, ry, rz);
        n_fail++;
      end
    endfunction

    function int pending();
      return expected_rot.size();
    endfunction

    function void close();
      if (expected_rot.size() != 0) begin
        $display("%0d results never arrived", expected_rot.size());
        n_fail += expected_rot.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  longint cycle_cnt;
  rotation_scoreboard sb;

  avr_req_if #(.COORD_BITS(CW)) req_if ();
  avr_res_if #(.COORD_BITS(CW)) res_if ();

  axis_vector_rotator_core #(
    .CORDIC_STEPS(STEPS),
    .COORD_BITS  (CW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt == CYCLE_CAP);
    $display("[axis_vector_rotator_core] ERROR");
    $finish;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_coord();
    logic [15:0] v;
    if ($urandom_range(0, 99) >= 12)
      return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 4))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      default: v = 16'h0001;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] v;
    if ($urandom_range(0, 99) >= 10)
      return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0: v = 16'h0000;
      1: v = 16'h3FFF;
      2: v = 16'h4000;
      3: v = 16'h7FFF;
      4: v = 16'h8000;
      5: v = 16'hBFFF;
      6: v = 16'hC000;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // result side: random backpressure, calm for one stretch in three
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = pick_gap(((cycle_cnt / 300) % 3) == 0);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready)
      sb.note_request(req_if.req_type, req_if.angle, req_if.coord_x, req_if.coord_y,
                      req_if.coord_z);
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.rot_x, res_if.rot_y, res_if.rot_z);
  end

  task automatic send_vector(input logic [1:0] axis, input logic [15:0] angle,
                             input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] cz, input int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= axis;
    req_if.angle    <= angle;
    req_if.coord_x  <= cx;
    req_if.coord_y  <= cy;
    req_if.coord_z  <= cz;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int          k;
    logic [1:0]  axis;
    sb = new();
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.req_type <= '0;
    req_if.angle    <= '0;
    req_if.coord_x  <= '0;
    req_if.coord_y  <= '0;
    req_if.coord_z  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // quarter-turn edges, extreme coordinates, every axis code
    for (k = 0; k < 4; k++)
      send_vector(2'(k), 16'h4000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
    for (k = 0; k < 3; k++)
      send_vector(2'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    for (k = 0; k < 3; k++)
      send_vector(2'(k), 16'hC000, 16'h7FFF, 16'h7FFF, 16'h8000, 1);
    send_vector(AXIS_X, 16'h3FFF, 16'hFFFF, 16'h0001, 16'h0000, 0);
    send_vector(AXIS_Y, 16'hBFFF, 16'h0001, 16'hFFFF, 16'h8000, 0);
    send_vector(AXIS_Z, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 0);
    send_vector(AXIS_X, 16'h0000, 16'h1234, 16'h7FFF, 16'h8000, 2);
    send_vector(AXIS_Y, 16'h2000, 16'h0100, 16'h0000, 16'h0100, 0);
    send_vector(AXIS_Z, 16'hE000, 16'h8000, 16'h8000, 16'h0000, 0);
    send_vector(AXIS_NONE, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 0);
    send_vector(AXIS_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
    send_vector(AXIS_Z, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0);
    send_vector(AXIS_X, 16'h8001, 16'h0000, 16'h7FFF, 16'h7FFF, 0);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2)
        wait_drained();
      axis = ($urandom_range(0, 99) < 8) ? AXIS_NONE : 2'($urandom_range(0, 2));
      send_vector(axis, pick_angle(), pick_coord(), pick_coord(), pick_coord(),
                  pick_gap(((k / 128) % 3) == 1));
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    sb.close();
    $display("covered %0d vectors: %0d about x, %0d about y, %0d about z, %0d pass-through",
             sb.n_sent, sb.per_axis[0], sb.per_axis[1], sb.per_axis[2], sb.per_axis[3]);
    $display("compared %0d results under random gaps and backpressure, %0d failures",
             sb.n_checked, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("[axis_vector_rotator_core] OK");
    end else begin
      $display("[axis_vector_rotator_core] ERROR");
    end
    $finish;
  end

endmodule
